>>> hw/rtl/fea_pkg.sv
// ============================================================================
// fea_pkg
// Shared types and constants of the fade envelope alpha controller.
// ============================================================================
package fea_pkg;

    // default width of the time registers and the tick amount
    localparam int TIME_BITS_DEF = 16;

    // quotient bits of the ramp divide (alpha is 8 bits)
    localparam int ALPHA_BITS = 8;

    localparam logic [ALPHA_BITS-1:0] ALPHA_FULL = 8'hFF;

    // register indexes
    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_HOLD     = 2'd1;
    localparam logic [1:0] REG_FADE_IN  = 2'd2;
    localparam logic [1:0] REG_FADE_OUT = 2'd3;

    // fade modes
    localparam logic [1:0] MODE_IN    = 2'd0;
    localparam logic [1:0] MODE_OUT   = 2'd1;
    localparam logic [1:0] MODE_INOUT = 2'd2;

    // actions
    localparam logic ACT_PLAY = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_IN   = 3'd1,
        PH_HOLD = 3'd2,
        PH_OUT  = 3'd3,
        PH_DONE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_CALC,
        SQ_CHECK,
        SQ_DIV,
        SQ_DONE
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

>>> hw/rtl/fea_div.sv
// ============================================================================
// fea_div
// Bit-serial restoring divide giving floor(255*e/d) for e < d, one quotient
// bit per cycle.
// ============================================================================
module fea_div #(
    parameter int TIME_BITS = fea_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [TIME_BITS-1:0]            elapsed,
    input  logic [TIME_BITS-1:0]            duration,
    output fea_pkg::div_sts_t               sts,
    output logic [fea_pkg::ALPHA_BITS-1:0]  quo
);

    localparam int QB = fea_pkg::ALPHA_BITS;
    localparam int NB = TIME_BITS + QB;

    logic [NB-1:0]        prod;
    logic [TIME_BITS:0]   trial;
    logic [TIME_BITS:0]   diff;
    logic                 fits;

    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [QB-1:0]        low_reg, low_next;
    logic [QB-1:0]        quo_reg, quo_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // 255*e as 256*e - e; since e < d the top bits are already below d
    assign prod  = {elapsed, {QB{1'b0}}} - {{QB{1'b0}}, elapsed};
    assign trial = {rem_reg, low_reg[QB-1]};
    assign diff  = trial - {1'b0, duration};
    assign fits  = trial >= {1'b0, duration};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = prod[NB-1:QB];
            low_next  = prod[QB-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            low_next = {low_reg[QB-2:0], 1'b0};
            quo_next = {quo_reg[QB-2:0], fits};
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'(QB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule

>>> hw/rtl/fade_envelope_alpha_controller.sv
// ============================================================================
// fade_envelope_alpha_controller
// Alpha envelope for fading a layer or LED: fade in, hold, fade out.
// ============================================================================
// The input channel (in_valid, in_stall, action, delta_ticks) takes play and
// tick items; every item gives one result (alpha, phase) on the output
// channel (out_valid, out_stall). The APB port sets fade_mode, hold_ticks,
// fade_in_ticks and fade_out_ticks at byte addresses 0, 4, 8 and 12.
// An item is processed alone, from acceptance to its result register:
//   play, or a tick outside a ramp or hold: states CALC, DONE
//   tick while holding, or a tick that ends a ramp: CALC, CHECK, DONE
//   any other tick during a ramp: CALC, CHECK, DIV, DONE, where DIV waits
//   for the bit-serial divide (one alpha bit per cycle) in fea_div
// The next item is accepted in the cycle after the previous one is loaded into
// the output register, even while that result still waits there.
// A stalled receiver holds the result; a finished item then waits in the
// sequencer and the input stalls until the output register frees up.
// Reset clears the control, envelope and configuration registers: phase idle, alpha 0, all times 0, mode 0.
// ============================================================================
module fade_envelope_alpha_controller #(
    parameter int TIME_BITS = fea_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // item input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 action,
    input  logic [TIME_BITS-1:0] delta_ticks,
    // result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           alpha,
    output logic [2:0]           phase,
    // configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AB = TIME_BITS + 1;

    // configuration registers
    logic [1:0]           mode_reg;
    logic [TIME_BITS-1:0] hold_ticks_reg;
    logic [TIME_BITS-1:0] fade_in_reg;
    logic [TIME_BITS-1:0] fade_out_reg;
    logic                 cfg_wr;

    // sequencer
    fea_pkg::seq_state_t  seq_reg, seq_next;
    logic                 in_xfer;
    logic                 out_free;

    // item
    logic                 act_reg;
    logic [TIME_BITS-1:0] delta_reg;

    // envelope state
    fea_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]           alpha_reg, alpha_next;
    logic [AB-1:0]        ramp_reg, ramp_next;
    logic [AB-1:0]        hold_reg, hold_next;

    // result register
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_alpha_reg;
    fea_pkg::phase_t      out_phase_reg;

    // datapath
    logic [AB:0]          ramp_sum;
    logic [AB:0]          hold_sum;
    logic [AB-1:0]        ramp_sat;
    logic [AB-1:0]        hold_sat;
    logic [TIME_BITS-1:0] dur_sel;
    logic                 ramp_full;
    logic                 hold_over;
    logic                 ramp_phase;
    logic                 div_start;
    fea_pkg::div_sts_t    div_sts;
    logic [7:0]           div_quo;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= '0;
            hold_ticks_reg <= '0;
            fade_in_reg    <= '0;
            fade_out_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                fea_pkg::REG_MODE:     mode_reg       <= pwdata[1:0];
                fea_pkg::REG_HOLD:     hold_ticks_reg <= pwdata[TIME_BITS-1:0];
                fea_pkg::REG_FADE_IN:  fade_in_reg    <= pwdata[TIME_BITS-1:0];
                fea_pkg::REG_FADE_OUT: fade_out_reg   <= pwdata[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fea_pkg::REG_MODE:     prdata = {30'd0, mode_reg};
            fea_pkg::REG_HOLD:     prdata = 32'(hold_ticks_reg);
            fea_pkg::REG_FADE_IN:  prdata = 32'(fade_in_reg);
            fea_pkg::REG_FADE_OUT: prdata = 32'(fade_out_reg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    assign ramp_sum = {1'b0, ramp_reg} + {2'b00, delta_reg};
    assign hold_sum = {1'b0, hold_reg} + {2'b00, delta_reg};
    // saturating accumulators
    assign ramp_sat = ramp_sum[AB] ? '1 : ramp_sum[AB-1:0];
    assign hold_sat = hold_sum[AB] ? '1 : hold_sum[AB-1:0];

    assign ramp_phase = phase_reg inside {fea_pkg::PH_IN, fea_pkg::PH_OUT};
    assign dur_sel    = (phase_reg == fea_pkg::PH_IN) ? fade_in_reg : fade_out_reg;
    assign ramp_full  = (dur_sel == '0) || (ramp_reg >= {1'b0, dur_sel});
    assign hold_over  = hold_reg >= {1'b0, hold_ticks_reg};

    fea_div #(
        .TIME_BITS (TIME_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .elapsed  (ramp_reg[TIME_BITS-1:0]),
        .duration (dur_sel),
        .sts      (div_sts),
        .quo      (div_quo)
    );

    // envelope state update
    always_comb
    begin
        phase_next = phase_reg;
        alpha_next = alpha_reg;
        ramp_next  = ramp_reg;
        hold_next  = hold_reg;
        div_start  = 1'b0;
        case (seq_reg)
            fea_pkg::SQ_CALC:
            begin
                if (act_reg == fea_pkg::ACT_PLAY)
                begin
                    ramp_next = '0;
                    if (mode_reg inside {fea_pkg::MODE_IN, fea_pkg::MODE_INOUT})
                    begin
                        alpha_next = '0;
                        phase_next = fea_pkg::PH_IN;
                    end
                    else if (mode_reg == fea_pkg::MODE_OUT)
                    begin
                        alpha_next = fea_pkg::ALPHA_FULL;
                        if (hold_ticks_reg != '0)
                        begin
                            hold_next  = '0;
                            phase_next = fea_pkg::PH_HOLD;
                        end
                        else
                        begin
                            phase_next = fea_pkg::PH_OUT;
                        end
                    end
                end
                else if (ramp_phase)
                begin
                    ramp_next = ramp_sat;
                end
                else if (phase_reg == fea_pkg::PH_HOLD)
                begin
                    hold_next = hold_sat;
                end
            end
            fea_pkg::SQ_CHECK:
            begin
                if (phase_reg == fea_pkg::PH_IN)
                begin
                    if (ramp_full)
                    begin
                        ramp_next  = '0;
                        alpha_next = fea_pkg::ALPHA_FULL;
                        if (hold_ticks_reg != '0)
                        begin
                            hold_next  = '0;
                            phase_next = fea_pkg::PH_HOLD;
                        end
                        else if (mode_reg == fea_pkg::MODE_IN)
                        begin
                            phase_next = fea_pkg::PH_DONE;
                        end
                        else if (mode_reg inside {fea_pkg::MODE_OUT, fea_pkg::MODE_INOUT})
                        begin
                            phase_next = fea_pkg::PH_OUT;
                        end
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                else if (phase_reg == fea_pkg::PH_OUT)
                begin
                    if (ramp_full)
                    begin
                        alpha_next = '0;
                        phase_next = fea_pkg::PH_DONE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
                else if (phase_reg == fea_pkg::PH_HOLD && hold_over)
                begin
                    // end of hold; mode 3 leaves the phase as it is
                    if (mode_reg == fea_pkg::MODE_IN)
                    begin
                        phase_next = fea_pkg::PH_DONE;
                    end
                    else if (mode_reg inside {fea_pkg::MODE_OUT, fea_pkg::MODE_INOUT})
                    begin
                        ramp_next  = '0;
                        phase_next = fea_pkg::PH_OUT;
                    end
                end
            end
            fea_pkg::SQ_DIV:
            begin
                if (div_sts.done)
                begin
                    alpha_next = (phase_reg == fea_pkg::PH_IN) ?
                                 div_quo : fea_pkg::ALPHA_FULL - div_quo;
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------------
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            fea_pkg::SQ_IDLE:
            begin
                if (in_xfer)
                    seq_next = fea_pkg::SQ_CALC;
            end
            fea_pkg::SQ_CALC:
            begin
                if (act_reg == fea_pkg::ACT_TICK &&
                    (ramp_phase || phase_reg == fea_pkg::PH_HOLD))
                    seq_next = fea_pkg::SQ_CHECK;
                else
                    seq_next = fea_pkg::SQ_DONE;
            end
            fea_pkg::SQ_CHECK:
            begin
                if (ramp_phase && !ramp_full)
                    seq_next = fea_pkg::SQ_DIV;
                else
                    seq_next = fea_pkg::SQ_DONE;
            end
            fea_pkg::SQ_DIV:
            begin
                if (div_sts.done)
                    seq_next = fea_pkg::SQ_DONE;
            end
            fea_pkg::SQ_DONE:
            begin
                if (out_free)
                    seq_next = fea_pkg::SQ_IDLE;
            end
            default: seq_next = fea_pkg::SQ_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall       = (seq_reg != fea_pkg::SQ_IDLE);
        out_valid_next = out_valid_reg && out_stall;
        if (seq_reg == fea_pkg::SQ_DONE && out_free)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= fea_pkg::SQ_IDLE;
            phase_reg     <= fea_pkg::PH_IDLE;
            alpha_reg     <= '0;
            ramp_reg      <= '0;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            alpha_reg     <= alpha_next;
            ramp_reg      <= ramp_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg   <= action;
            delta_reg <= delta_ticks;
        end
        if (seq_reg == fea_pkg::SQ_DONE && out_free)
        begin
            out_alpha_reg <= alpha_reg;
            out_phase_reg <= phase_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign alpha     = out_alpha_reg;
    assign phase     = out_phase_reg;

`ifndef SYNTHESIS
    // the divider only starts on a ramp that has not yet reached its end
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (ramp_reg < {1'b0, dur_sel}) && (dur_sel != '0))
        else $error("divide started on a finished ramp");

    // a quotient is only delivered while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> seq_reg == fea_pkg::SQ_DIV)
        else $error("divide finished outside the divide step");

    // a new result only appears after an item has been completed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(seq_reg == fea_pkg::SQ_DONE))
        else $error("result presented without a finished item");

    // the divider is only busy while the sequencer sits in its divide step
    assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.busy |-> seq_reg == fea_pkg::SQ_DIV)
        else $error("divider running outside the divide step");
`endif

endmodule

>>> bench/fea_envelope_checker.sv
// ----------------------------------------------------------------------------
// fea_envelope_checker
// Watches the item, result and register channels of the fade envelope
// controller, keeps its own copy of the envelope state, predicts alpha and
// phase for every accepted item and compares them with the results in order.
// ----------------------------------------------------------------------------
module fea_envelope_checker
    import fea_pkg::*;
#(
    parameter int TW = TIME_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  logic          action,
    input  logic [TW-1:0] delta_ticks,
    input  logic          out_valid,
    input  logic          out_stall,
    input  logic [7:0]    alpha,
    input  logic [2:0]    phase,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    input  logic          pready,
    output int            mismatches,
    output int            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [TW:0] ACC_TOP = '1;

    typedef struct packed {
        logic [7:0] alpha;
        phase_t     phase;
    } level_t;

    level_t level_q[$];

    logic [1:0]    cfg_mode;
    logic [TW-1:0] cfg_hold;
    logic [TW-1:0] cfg_in;
    logic [TW-1:0] cfg_out;

    phase_t        env_phase;
    logic [7:0]    env_alpha;
    logic [TW:0]   ramp_acc;
    logic [TW:0]   hold_acc;

    int            fail_count;

    function automatic logic [TW:0] acc_add(input logic [TW:0] a, input logic [TW-1:0] b);
        logic [TW+1:0] s;
        s = a + b;
        return (s > {1'b0, ACC_TOP}) ? ACC_TOP : s[TW:0];
    endfunction

    // floor(255*e/d), saturating at 255 once e reaches d or d is zero
    function automatic logic [7:0] ramp_level(input logic [TW:0] e, input logic [TW-1:0] d,
                                              output logic full);
        logic [47:0] prod;
        if (d == '0 || e >= {1'b0, d})
        begin
            full = 1'b1;
            return ALPHA_FULL;
        end
        full = 1'b0;
        prod = 48'(e) * 48'd255;
        return 8'(prod / 48'(d));
    endfunction

    function automatic void finish_hold();
        case (cfg_mode)
            MODE_IN: env_phase = PH_DONE;
            MODE_OUT, MODE_INOUT:
            begin
                ramp_acc  = '0;
                env_phase = PH_OUT;
            end
            default: ;
        endcase
    endfunction

    function automatic void enter_hold();
        if (cfg_hold == '0)
        begin
            finish_hold();
        end
        else
        begin
            hold_acc  = '0;
            env_phase = PH_HOLD;
        end
    endfunction

    function automatic void advance_envelope(input logic act, input logic [TW-1:0] d);
        logic       full;
        logic [7:0] lvl;
        if (act == ACT_PLAY)
        begin
            ramp_acc = '0;
            if (cfg_mode == MODE_IN || cfg_mode == MODE_INOUT)
            begin
                env_alpha = '0;
                env_phase = PH_IN;
            end
            else if (cfg_mode == MODE_OUT)
            begin
                env_alpha = ALPHA_FULL;
                enter_hold();
            end
        end
        else
        begin
            case (env_phase)
                PH_IN:
                begin
                    ramp_acc  = acc_add(ramp_acc, d);
                    lvl       = ramp_level(ramp_acc, cfg_in, full);
                    env_alpha = lvl;
                    if (full)
                    begin
                        ramp_acc  = '0;
                        env_alpha = ALPHA_FULL;
                        enter_hold();
                    end
                end
                PH_HOLD:
                begin
                    hold_acc = acc_add(hold_acc, d);
                    if (hold_acc >= {1'b0, cfg_hold})
                        finish_hold();
                end
                PH_OUT:
                begin
                    ramp_acc  = acc_add(ramp_acc, d);
                    lvl       = ramp_level(ramp_acc, cfg_out, full);
                    env_alpha = ALPHA_FULL - lvl;
                    if (full)
                    begin
                        env_alpha = '0;
                        env_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        level_t want;
        if (!rst_n)
        begin
            cfg_mode   = MODE_IN;
            cfg_hold   = '0;
            cfg_in     = '0;
            cfg_out    = '0;
            env_phase  = PH_IDLE;
            env_alpha  = '0;
            ramp_acc   = '0;
            hold_acc   = '0;
            fail_count = 0;
            level_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MODE:     cfg_mode = pwdata[1:0];
                    REG_HOLD:     cfg_hold = pwdata[TW-1:0];
                    REG_FADE_IN:  cfg_in   = pwdata[TW-1:0];
                    REG_FADE_OUT: cfg_out  = pwdata[TW-1:0];
                    default: ;
                endcase
            end

            // results leave before this edge's item is queued
            if (out_valid && !out_stall)
            begin
                if (level_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result: alpha %0d phase %0d",
                                 $realtime, alpha, phase);
                end
                else
                begin
                    want = level_q.pop_front();
                    if (alpha !== want.alpha || phase !== want.phase)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"[%0t] result mismatch: alpha %0d phase %0d, ",
                                      "expected alpha %0d phase %0d"},
                                     $realtime, alpha, phase, want.alpha, want.phase);
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                advance_envelope(action, delta_ticks);
                want.alpha = env_alpha;
                want.phase = env_phase;
                level_q.push_back(want);
            end

            mismatches  <= fail_count;
            outstanding <= level_q.size();
        end
    end

endmodule

>>> bench/fade_envelope_alpha_controller_tb.sv
// ----------------------------------------------------------------------------
// fade_envelope_alpha_controller_tb
// Drives play and tick transfers and register writes into the fade envelope
// controller: a directed pass over the corner cases, then random play/tick
// sequences under several register settings and sender/receiver idle mixes.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module fade_envelope_alpha_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fea_pkg::*;

    localparam int         TW           = TIME_BITS_DEF;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RAND_PHASES  = 16;
    localparam int         PHASE_ITEMS  = 97;
    localparam int         SETTLE       = 30;
    localparam int         CYCLE_LIMIT  = 600000;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    logic          action = ACT_PLAY;
    logic [TW-1:0] delta_ticks = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [7:0]    alpha;
    logic [2:0]    phase;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    int            mismatches;
    int            outstanding;
    int            idle_pct = 0;
    int            stall_pct = 0;
    int            cycle_count = 0;
    int            delta_lim = 1;

    fade_envelope_alpha_controller #(.TIME_BITS(TW)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .delta_ticks(delta_ticks),
        .out_valid(out_valid), .out_stall(out_stall),
        .alpha(alpha), .phase(phase),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    fea_envelope_checker #(.TW(TW)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .delta_ticks(delta_ticks),
        .out_valid(out_valid), .out_stall(out_stall),
        .alpha(alpha), .phase(phase),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one transfer; valid stays high afterwards unless the next call idles
    task automatic send_item(input logic act, input logic [TW-1:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        delta_ticks <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    // block must be drained before this is called
    task automatic program_envelope(input logic [1:0] mode, input logic [TW-1:0] hold,
                                    input logic [TW-1:0] fin, input logic [TW-1:0] fout);
        int longest;
        apb_write(REG_MODE, 32'(mode));
        apb_write(REG_HOLD, 32'(hold));
        apb_write(REG_FADE_IN, 32'(fin));
        apb_write(REG_FADE_OUT, 32'(fout));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        longest = (fin > fout) ? int'(fin) : int'(fout);
        if (int'(hold) > longest)
            longest = int'(hold);
        delta_lim = longest / 5 + 1;
    endtask

    function automatic logic [TW-1:0] pick_duration();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return TW'($urandom);
            default: return TW'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_delta();
        case ($urandom_range(11))
            0:       return '0;
            1:       return '1;
            2:       return TW'($urandom);
            default: return TW'($urandom_range(delta_lim));
        endcase
    endfunction

    initial
    begin
        logic [1:0] mode;
        int         sent;
        int         run_len;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: tick while idle, zero-length fade in, hold skipped
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_PLAY, '1);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_TICK, '1);
        wait_drained();

        // longest ramps with a short hold, largest tick amounts
        program_envelope(MODE_INOUT, 16'd3, '1, '1);
        send_item(ACT_PLAY, 16'd0);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_TICK, 16'd32767);
        send_item(ACT_TICK, '1);
        send_item(ACT_TICK, 16'd1);
        send_item(ACT_TICK, 16'd2);
        send_item(ACT_TICK, 16'd32767);
        send_item(ACT_TICK, '1);
        wait_drained();

        // fade out with no hold and zero duration
        program_envelope(MODE_OUT, 16'd0, 16'd0, 16'd0);
        send_item(ACT_PLAY, 16'hA5A5);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_TICK, 16'd5);
        wait_drained();

        // unused mode: play keeps phase and alpha
        program_envelope(MODE_UNUSED, 16'd0, 16'd7, 16'd7);
        send_item(ACT_PLAY, 16'd0);
        send_item(ACT_TICK, 16'd9);
        wait_drained();

        // mode switched while a sequence is running
        program_envelope(MODE_IN, 16'd5, 16'd10, 16'd4);
        send_item(ACT_PLAY, 16'd0);
        send_item(ACT_TICK, 16'd3);
        wait_drained();
        program_envelope(MODE_UNUSED, 16'd5, 16'd10, 16'd4);
        send_item(ACT_TICK, 16'd7);
        send_item(ACT_TICK, 16'd10);
        wait_drained();
        program_envelope(MODE_OUT, 16'd5, 16'd10, 16'd4);
        send_item(ACT_TICK, 16'd0);
        send_item(ACT_TICK, 16'd3);
        send_item(ACT_TICK, 16'd1);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 69;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 69;
                end
                default:
                begin
                    idle_pct  = 34;
                    stall_pct = 34;
                end
            endcase
            mode = ($urandom_range(7) == 0) ? MODE_UNUSED : 2'($urandom_range(2));
            program_envelope(mode, pick_duration(), pick_duration(), pick_duration());

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                send_item(ACT_PLAY, TW'($urandom));
                sent++;
                run_len = $urandom_range(30, 2);
                for (int k = 0; k < run_len && sent < PHASE_ITEMS; k++)
                begin
                    // occasional stray play inside a run
                    if ($urandom_range(15) == 0)
                        send_item(ACT_PLAY, TW'($urandom));
                    else
                        send_item(ACT_TICK, pick_delta());
                    sent++;
                    if (p % 2 == 0 && sent == PHASE_ITEMS / 2)
                        wait_drained();
                end
            end
            wait_drained();
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();

        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/fea_pkg.sv
hw/rtl/fea_div.sv
hw/rtl/fade_envelope_alpha_controller.sv
bench/fea_envelope_checker.sv
bench/fade_envelope_alpha_controller_tb.sv
